FILE: sv/p2c_pkg.sv
// ============================================================================
// Polar-to-Cartesian resample package
// Shared constants, types and the arctangent table for the scan converter.
// ============================================================================
package p2c_pkg;

    // Grid geometry: both bin counts are powers of two.
    localparam int RAD_W        = 8;
    localparam int ANG_W        = 8;
    localparam int FRAC_W       = 16;
    localparam int BANK_AW      = (RAD_W - 1) + (ANG_W - 1);
    localparam int BANK_DEPTH   = 1 << BANK_AW;

    // Lengths of the two cell chains, and the count of CORDIC steps within the first.
    localparam int SQ_STEPS     = 33;
    localparam int CORDIC_STEPS = 32;
    localparam int DIV_STEPS    = RAD_W + FRAC_W;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_OUTER = 2'd0,
        CFG_INNER = 2'd1,
        CFG_PHASE = 2'd2
    } t_cfg_idx;

    // Word handed along the square root and CORDIC chain.
    typedef struct packed {
        logic               vld;
        logic               outside;
        logic [65:0]        rad;
        logic [33:0]        root;
        logic [35:0]        rem;
        logic signed [43:0] cx;
        logic signed [43:0] cy;
        logic [31:0]        z;
        logic               hold;
    } t_cell;

    // Word handed along the radial divider chain.
    typedef struct packed {
        logic                 vld;
        logic                 outside;
        logic [31:0]          rem;
        logic [DIV_STEPS-1:0] quo;
        logic [ANG_W-1:0]     ip;
        logic [FRAC_W-1:0]    frac_b;
    } t_div;

    // Arctangent of 2^-idx in 2^-32 turn units.
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/p2c_cell.sv
// ============================================================================
// Square root and CORDIC cell
// Restoring square root step; vectoring CORDIC step while STEP < CORDIC_STEPS.
// ============================================================================
module p2c_cell
    import p2c_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell              n_cell;
    t_cell              r_cell;
    logic [35:0]        rem2;
    logic [35:0]        trial;
    logic signed [43:0] dx;
    logic signed [43:0] dy;

    // Both steps work on the word as it enters the cell.
    always_comb begin
        n_cell     = i_cell;
        n_cell.vld = i_cell.vld & i_rst_n;
        // Square root: bring down the next bit pair and try to subtract.
        rem2   = {i_cell.rem[33:0], i_cell.rad[65:64]};
        trial  = {i_cell.root, 2'b01};
        n_cell.rad = {i_cell.rad[63:0], 2'b00};
        if (rem2 >= trial) begin
            n_cell.rem  = rem2 - trial;
            n_cell.root = {i_cell.root[32:0], 1'b1};
        end else begin
            n_cell.rem  = rem2;
            n_cell.root = {i_cell.root[32:0], 1'b0};
        end
        // CORDIC: rotate toward the x axis and accumulate the angle.
        dx = i_cell.cx >>> STEP;
        dy = i_cell.cy >>> STEP;
        if (STEP < CORDIC_STEPS && !i_cell.hold) begin
            if (!i_cell.cy[43]) begin
                n_cell.cx = i_cell.cx + dy;
                n_cell.cy = i_cell.cy - dx;
                n_cell.z  = i_cell.z + atan_turn(STEP);
            end else begin
                n_cell.cx = i_cell.cx - dy;
                n_cell.cy = i_cell.cy + dx;
                n_cell.z  = i_cell.z - atan_turn(STEP);
            end
        end
    end

    // Hand the word to the next cell.
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

FILE: sv/p2c_div_cell.sv
// ============================================================================
// Radial divider cell
// One restoring division step of the radial bin and fraction quotient.
// ============================================================================
module p2c_div_cell
    import p2c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_den,
    input  t_div        i_div,
    output t_div        o_div
);

    t_div        n_div;
    t_div        r_div;
    logic [32:0] shifted;
    logic [32:0] diff;

    // The dividend below the remainder is all zeros, so only a shift enters.
    always_comb begin
        n_div     = i_div;
        n_div.vld = i_div.vld & i_rst_n;
        shifted = {i_div.rem, 1'b0};
        diff    = shifted - {1'b0, i_den};
        if (shifted >= {1'b0, i_den}) begin
            n_div.rem = diff[31:0];
            n_div.quo = {i_div.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            n_div.rem = shifted[31:0];
            n_div.quo = {i_div.quo[DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_div = r_div;

endmodule

FILE: sv/p2c_bank.sv
// ============================================================================
// Grid bank
// One quarter of the polar grid: one write port and one registered read port.
// ============================================================================
module p2c_bank
    import p2c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [BANK_AW-1:0] i_waddr,
    input  logic [31:0]        i_wdata,
    input  logic [BANK_AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);

    logic [31:0] r_mem [0:BANK_DEPTH-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/polar_to_cartesian_resample_unit.sv
// ============================================================================
// Polar-to-Cartesian resample unit
// Scan-converts a stored polar grid into Cartesian pixels with bilinear blend.
// ============================================================================
// Usage:
//  A word is taken at a rising edge with i_start high and o_busy low. A load
//  word (i_req_type 0) stores i_sample_value at bin (radial, angular); a pixel
//  word (i_req_type 1) converts pixel (i_pixel_x, i_pixel_y). o_busy is high
//  only while reset is held, so one word can enter on every cycle.
//  Each pixel word gives one result: o_valid is high for exactly one cycle
//  with o_pixel_value and o_outside. A load word gives no result. Between
//  entry and output lie four entry stages, the 33-cell square root and
//  CORDIC chain, one range check stage, the 24-cell radial divider, the grid
//  read stage and four blend stages. Loads ride a matching delay line
//  and write the grid at the read stage, so every result sees exactly the
//  loads that came before its pixel word.
//  Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
//  no word is in flight. Reset restores the register defaults and empties
//  the pipeline; the grid is not cleared and must be loaded before use.
//  The receiver cannot stall: each result is shown for one cycle only.
// ============================================================================
module polar_to_cartesian_resample_unit
    import p2c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_req_type,
    input  logic [RAD_W-1:0]   i_grid_radial,
    input  logic [ANG_W-1:0]   i_grid_angular,
    input  logic signed [31:0] i_sample_value,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic signed [31:0] o_pixel_value,
    output logic               o_outside
);

    localparam int LD_DEPTH = 4 + SQ_STEPS + 1 + DIV_STEPS;
    localparam int LATENCY  = LD_DEPTH + 5;

    typedef struct packed {
        logic               vld;
        logic [RAD_W-1:0]   radial;
        logic [ANG_W-1:0]   angular;
        logic [31:0]        value;
    } t_load;

    logic w_acc;

    // Configuration registers.
    logic [31:0] r_cfg_outer;
    logic [31:0] r_cfg_inner;
    logic [15:0] r_cfg_phase;
    logic [31:0] w_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_outer <= 32'd65536;
            r_cfg_inner <= 32'd0;
            r_cfg_phase <= 16'd32768;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUTER: r_cfg_outer <= i_cfg_wdata;
                CFG_INNER: r_cfg_inner <= i_cfg_wdata;
                CFG_PHASE: r_cfg_phase <= i_cfg_wdata[15:0];
                default:   ;
            endcase
        end
    end

    assign w_den  = r_cfg_outer - r_cfg_inner;
    assign o_busy = ~i_rst_n;
    assign w_acc  = i_start & ~o_busy;

    // Entry register for pixel words.
    logic       r_s0_vld;
    logic [7:0] r_s0_ix;
    logic [7:0] r_s0_iy;

    always_ff @(posedge i_clk) begin
        r_s0_ix  <= i_pixel_x;
        r_s0_iy  <= i_pixel_y;
        r_s0_vld <= i_rst_n & w_acc & (i_req_type == REQ_PIXEL);
    end

    // Load words ride a delay line that ends at the grid read stage.
    t_load r_ld [0:LD_DEPTH-1];

    always_ff @(posedge i_clk) begin
        r_ld[0].radial  <= i_grid_radial;
        r_ld[0].angular <= i_grid_angular;
        r_ld[0].value   <= i_sample_value;
        r_ld[0].vld     <= i_rst_n & w_acc & (i_req_type == REQ_LOAD);
        for (int i = 1; i < LD_DEPTH; i++) begin
            r_ld[i] <= {r_ld[i-1].vld & i_rst_n, r_ld[i-1].radial,
                        r_ld[i-1].angular, r_ld[i-1].value};
        end
    end

    // Stage A: pixel position in Q16.16 spanning plus or minus the outer radius.
    logic [39:0]        w_px;
    logic [39:0]        w_py;
    logic signed [33:0] w_xa;
    logic signed [33:0] w_ya;
    logic signed [33:0] w_rs;
    logic               r_a_vld;
    logic               r_a_out;
    logic signed [33:0] r_a_x;
    logic signed [33:0] r_a_y;

    assign w_px = 40'(r_s0_ix) * 40'(r_cfg_outer);
    assign w_py = 40'(r_s0_iy) * 40'(r_cfg_outer);
    assign w_rs = $signed({2'b00, r_cfg_outer});
    assign w_xa = $signed({1'b0, w_px[39:RAD_W-1]}) - w_rs;
    assign w_ya = $signed({1'b0, w_py[39:ANG_W-1]}) - w_rs;

    always_ff @(posedge i_clk) begin
        r_a_x   <= w_xa;
        r_a_y   <= w_ya;
        r_a_out <= (r_cfg_outer <= r_cfg_inner) | (w_xa > w_rs) | (w_ya > w_rs);
        r_a_vld <= i_rst_n & r_s0_vld;
    end

    // Stage B: squares of the magnitudes and the CORDIC half-plane fold.
    logic signed [33:0] w_ux;
    logic signed [33:0] w_uy;
    logic               w_neg;
    logic signed [33:0] w_fx;
    logic signed [33:0] w_fy;
    logic               r_b_vld;
    logic               r_b_out;
    logic [63:0]        r_b_sx;
    logic [63:0]        r_b_sy;
    logic signed [43:0] r_b_cx;
    logic signed [43:0] r_b_cy;
    logic [31:0]        r_b_z;
    logic               r_b_hold;

    assign w_ux  = r_a_x[33] ? -r_a_x : r_a_x;
    assign w_uy  = r_a_y[33] ? -r_a_y : r_a_y;
    assign w_neg = r_a_x[33];
    assign w_fx  = w_neg ? -r_a_x : r_a_x;
    assign w_fy  = w_neg ? -r_a_y : r_a_y;

    always_ff @(posedge i_clk) begin
        r_b_sx   <= 64'(w_ux[31:0]) * 64'(w_ux[31:0]);
        r_b_sy   <= 64'(w_uy[31:0]) * 64'(w_uy[31:0]);
        r_b_cx   <= {{2{w_fx[33]}}, w_fx, 8'h00};
        r_b_cy   <= {{2{w_fy[33]}}, w_fy, 8'h00};
        r_b_z    <= w_neg ? 32'h8000_0000 : 32'h0000_0000;
        r_b_hold <= (r_a_y == '0);
        r_b_out  <= r_a_out;
        r_b_vld  <= i_rst_n & r_a_vld;
    end

    // Stage C: sum of squares, the word that enters the cell chain.
    t_cell r_c;

    always_ff @(posedge i_clk) begin
        r_c.rad     <= {1'b0, 65'(r_b_sx) + 65'(r_b_sy)};
        r_c.root    <= '0;
        r_c.rem     <= '0;
        r_c.cx      <= r_b_cx;
        r_c.cy      <= r_b_cy;
        r_c.z       <= r_b_z;
        r_c.hold    <= r_b_hold;
        r_c.outside <= r_b_out;
        r_c.vld     <= i_rst_n & r_b_vld;
    end

    // Square root and CORDIC chain.
    t_cell w_cell [0:SQ_STEPS];

    assign w_cell[0] = r_c;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        p2c_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_cell[g]),
            .o_cell  (w_cell[g+1])
        );
    end

    // Stage D: radial range checks, rotated angle and its angular bin.
    t_cell       w_sq;
    logic [33:0] w_rd;
    logic [31:0] w_ang;
    t_div        r_d;

    assign w_sq  = w_cell[SQ_STEPS];
    assign w_rd  = w_sq.root - {2'b00, r_cfg_inner};
    assign w_ang = w_sq.z - {r_cfg_phase, 16'h0000};

    always_ff @(posedge i_clk) begin
        r_d.rem     <= w_rd[31:0];
        r_d.quo     <= '0;
        r_d.ip      <= w_ang[31 -: ANG_W];
        r_d.frac_b  <= w_ang[31-ANG_W -: FRAC_W];
        r_d.outside <= w_sq.outside | (w_sq.root < {2'b00, r_cfg_inner})
                       | (w_rd >= {2'b00, w_den});
        r_d.vld     <= i_rst_n & w_sq.vld;
    end

    // Radial divider chain.
    t_div w_div [0:DIV_STEPS];

    assign w_div[0] = r_d;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        p2c_div_cell u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (w_den),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    // Grid read: four banks split by radial and angular parity.
    t_div             w_dq;
    logic [RAD_W-1:0] w_ir;
    logic [31:0]      w_rdata [0:3];
    t_load            w_ld;
    logic             r_m_vld;
    logic             r_m_out;
    logic             r_m_ir0;
    logic             r_m_ip0;
    logic [FRAC_W-1:0] r_m_a;
    logic [FRAC_W-1:0] r_m_b;

    assign w_dq = w_div[DIV_STEPS];
    assign w_ir = w_dq.quo[DIV_STEPS-1 -: RAD_W];
    assign w_ld = r_ld[LD_DEPTH-1];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RAD_W-2:0] w_row;
        logic [ANG_W-2:0] w_col;
        logic             w_we;

        assign w_row = w_ir[RAD_W-1:1]
                       + (RAD_W-1)'((b / 2 == 0) && w_ir[0]);
        assign w_col = w_dq.ip[ANG_W-1:1]
                       + (ANG_W-1)'((b % 2 == 0) && w_dq.ip[0]);
        assign w_we  = w_ld.vld && (w_ld.radial[0] == 1'((b / 2) % 2))
                       && (w_ld.angular[0] == 1'(b % 2));

        p2c_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr ({w_ld.radial[RAD_W-1:1], w_ld.angular[ANG_W-1:1]}),
            .i_wdata (w_ld.value),
            .i_raddr ({w_row, w_col}),
            .o_rdata (w_rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        r_m_ir0 <= w_ir[0];
        r_m_ip0 <= w_dq.ip[0];
        r_m_a   <= w_dq.quo[FRAC_W-1:0];
        r_m_b   <= w_dq.frac_b;
        r_m_out <= w_dq.outside | (&w_ir);
        r_m_vld <= i_rst_n & w_dq.vld;
    end

    // Blend 1: radial weights times the four samples.
    logic signed [31:0] w_v00;
    logic signed [31:0] w_v10;
    logic signed [31:0] w_v01;
    logic signed [31:0] w_v11;
    logic signed [17:0] w_wa1;
    logic signed [17:0] w_wa0;
    logic signed [49:0] r_p00;
    logic signed [49:0] r_p10;
    logic signed [49:0] r_p01;
    logic signed [49:0] r_p11;
    logic               r_e1_vld;
    logic               r_e1_out;
    logic [FRAC_W-1:0]  r_e1_b;

    assign w_v00 = $signed(w_rdata[{r_m_ir0, r_m_ip0}]);
    assign w_v10 = $signed(w_rdata[{~r_m_ir0, r_m_ip0}]);
    assign w_v01 = $signed(w_rdata[{r_m_ir0, ~r_m_ip0}]);
    assign w_v11 = $signed(w_rdata[{~r_m_ir0, ~r_m_ip0}]);
    assign w_wa1 = $signed({2'b00, r_m_a});
    assign w_wa0 = $signed(18'h10000 - {2'b00, r_m_a});

    always_ff @(posedge i_clk) begin
        r_p00    <= w_v00 * w_wa0;
        r_p10    <= w_v10 * w_wa1;
        r_p01    <= w_v01 * w_wa0;
        r_p11    <= w_v11 * w_wa1;
        r_e1_b   <= r_m_b;
        r_e1_out <= r_m_out;
        r_e1_vld <= i_rst_n & r_m_vld;
    end

    // Blend 2: row sums, floored back to Q16.16.
    logic signed [50:0] w_s0;
    logic signed [50:0] w_s1;
    logic signed [31:0] r_t0;
    logic signed [31:0] r_t1;
    logic               r_e2_vld;
    logic               r_e2_out;
    logic [FRAC_W-1:0]  r_e2_b;

    assign w_s0 = 51'(r_p00) + 51'(r_p10);
    assign w_s1 = 51'(r_p01) + 51'(r_p11);

    always_ff @(posedge i_clk) begin
        r_t0     <= w_s0[47:16];
        r_t1     <= w_s1[47:16];
        r_e2_b   <= r_e1_b;
        r_e2_out <= r_e1_out;
        r_e2_vld <= i_rst_n & r_e1_vld;
    end

    // Blend 3: angular weights times the two rows.
    logic signed [17:0] w_wb1;
    logic signed [17:0] w_wb0;
    logic signed [49:0] r_q0;
    logic signed [49:0] r_q1;
    logic               r_e3_vld;
    logic               r_e3_out;

    assign w_wb1 = $signed({2'b00, r_e2_b});
    assign w_wb0 = $signed(18'h10000 - {2'b00, r_e2_b});

    always_ff @(posedge i_clk) begin
        r_q0     <= r_t0 * w_wb0;
        r_q1     <= r_t1 * w_wb1;
        r_e3_out <= r_e2_out;
        r_e3_vld <= i_rst_n & r_e2_vld;
    end

    // Blend 4: final sum into the output register.
    logic signed [50:0] w_qs;
    logic               r_out_vld;
    logic               r_out_out;
    logic signed [31:0] r_out_val;

    assign w_qs = 51'(r_q0) + 51'(r_q1);

    always_ff @(posedge i_clk) begin
        r_out_val <= r_e3_out ? 32'sd0 : w_qs[47:16];
        r_out_out <= r_e3_out;
        r_out_vld <= i_rst_n & r_e3_vld;
    end

    assign o_valid       = r_out_vld;
    assign o_pixel_value = r_out_val;
    assign o_outside     = r_out_out;

`ifndef ASSERT_OFF
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside) |-> (o_pixel_value == 32'sd0))
        else $error("outside pixel carries a nonzero value");

    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req_type == REQ_PIXEL) |-> ##LATENCY o_valid)
        else $error("pixel word did not produce a result on time");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req_type == REQ_LOAD) |-> ##LATENCY !o_valid)
        else $error("load word produced a result");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Polar-to-Cartesian resample unit testbench
// Loads grid samples and converts pixels under several register settings,
// predicting every pixel result and checking each one as it appears.
// ============================================================================
module tb;
    import p2c_pkg::*;

    // One request word for the block.
    typedef struct {
        logic        req;
        logic [7:0]  rad;
        logic [7:0]  ang;
        logic [31:0] sample;
        logic [7:0]  px;
        logic [7:0]  py;
    } t_word;

    // One predicted pixel result.
    typedef struct {
        logic [31:0] value;
        logic        outs;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_req_type = 1'b0;
    logic [7:0]         i_grid_radial = '0;
    logic [7:0]         i_grid_angular = '0;
    logic signed [31:0] i_sample_value = '0;
    logic [7:0]         i_pixel_x = '0;
    logic [7:0]         i_pixel_y = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_wdata = '0;
    logic               o_valid;
    logic signed [31:0] o_pixel_value;
    logic               o_outside;

    polar_to_cartesian_resample_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Register copies, the grid as the block holds it, and the written map.
    logic [31:0] outer_r = 32'd65536;
    logic [31:0] inner_r = 32'd0;
    logic [15:0] rot_ph  = 16'd32768;
    logic [31:0] grid_mem [65536];
    bit          written [65536];

    t_word  words_pending[$];
    t_pixel pixels_due[$];
    int     idle_pct = 17;
    int     quiet_cycles = 0;
    bit     failed = 1'b0;

    // Arctangent steps in 2^-32 turn units.
    logic [31:0] atan_steps [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0};

    // Floor square root of a sum of two squares.
    function automatic logic [33:0] floor_root(input logic [67:0] v);
        logic [33:0] root;
        logic [33:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            if (68'(cand) * 68'(cand) <= v) root = cand;
        end
        return root;
    endfunction

    // Pixel angle in turns by rotation steps; the origin has angle zero.
    function automatic logic [31:0] turn_of(input longint x0, input longint y0);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        if (y == 0) return z;
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < 32; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x = x + dy; y = y - dx; z = z + atan_steps[i];
            end else begin
                x = x - dy; y = y + dx; z = z - atan_steps[i];
            end
        end
        return z;
    endfunction

    // Maps a pixel to its radial and angular bins and fractions.
    function automatic void locate(input logic [7:0] px, input logic [7:0] py,
                                   output bit outs, output logic [7:0] ir,
                                   output logic [7:0] ip, output logic [15:0] fa,
                                   output logic [15:0] fb);
        longint      x;
        longint      y;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] r;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [31:0] p;
        logic [63:0] pa;
        outs = 1'b1;
        ir = '0; ip = '0; fa = '0; fb = '0;
        if (outer_r <= inner_r) return;
        x = longint'((64'(px) * 2 * 64'(outer_r)) >> 8) - longint'(outer_r);
        y = longint'((64'(py) * 2 * 64'(outer_r)) >> 8) - longint'(outer_r);
        if (x > longint'(outer_r) || y > longint'(outer_r)) return;
        ux = x < 0 ? -x : x;
        uy = y < 0 ? -y : y;
        r = 64'(floor_root(68'(ux) * 68'(ux) + 68'(uy) * 68'(uy)));
        if (r < 64'(inner_r)) return;
        num = 256 * (r - 64'(inner_r));
        den = 64'(outer_r) - 64'(inner_r);
        q = num / den;
        if (q + 1 >= 256) return;
        ir = q[7:0];
        fa = 16'(((num % den) << 16) / den);
        p  = turn_of(x, y) - {rot_ph, 16'h0};
        pa = 64'(p) * 256;
        ip = pa[39:32];
        fb = pa[31:16];
        outs = 1'b0;
    endfunction

    function automatic longint mix(input longint a, input longint b, input logic [15:0] f);
        return (a * (65536 - longint'(f)) + b * longint'(f)) >>> 16;
    endfunction

    function automatic longint cell_at(input logic [7:0] r, input logic [7:0] a);
        return longint'($signed(grid_mem[{r, a}]));
    endfunction

    // Expected result of one pixel word under the present grid.
    function automatic t_pixel convert_pixel(input logic [7:0] px, input logic [7:0] py);
        t_pixel      res;
        bit          outs;
        logic [7:0]  ir;
        logic [7:0]  ip;
        logic [15:0] fa;
        logic [15:0] fb;
        longint      t0;
        longint      t1;
        locate(px, py, outs, ir, ip, fa, fb);
        res.value = '0;
        res.outs  = 1'b1;
        if (!outs) begin
            t0 = mix(cell_at(ir, ip), cell_at(ir + 8'd1, ip), fa);
            t1 = mix(cell_at(ir, ip + 8'd1), cell_at(ir + 8'd1, ip + 8'd1), fa);
            res.value = 32'(mix(t0, t1, fb));
            res.outs  = 1'b0;
        end
        return res;
    endfunction

    task automatic push_load(input logic [7:0] r, input logic [7:0] a, input logic [31:0] v);
        t_word w;
        w = '{REQ_LOAD, r, a, v, 8'($urandom), 8'($urandom)};
        written[{r, a}] = 1'b1;
        words_pending = {words_pending, w};
    endtask

    // Queues a pixel word, first loading any grid entry it would read unwritten.
    task automatic push_pixel(input logic [7:0] px, input logic [7:0] py);
        t_word       w;
        bit          outs;
        logic [7:0]  ir;
        logic [7:0]  ip;
        logic [15:0] fa;
        logic [15:0] fb;
        locate(px, py, outs, ir, ip, fa, fb);
        if (!outs) begin
            for (int k = 0; k < 4; k++) begin
                if (!written[{ir + 8'(k / 2), ip + 8'(k % 2)}])
                    push_load(ir + 8'(k / 2), ip + 8'(k % 2), $urandom);
            end
        end
        w = '{REQ_PIXEL, 8'($urandom), 8'($urandom), $urandom, px, py};
        words_pending = {words_pending, w};
    endtask

    task automatic drain();
        wait (words_pending.size() == 0 && pixels_due.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        case (idx)
            CFG_OUTER: outer_r = v;
            CFG_INNER: inner_r = v;
            default:   rot_ph  = v[15:0];
        endcase
    endtask

    task automatic set_regs(input logic [31:0] o, input logic [31:0] n, input logic [15:0] ph);
        drain();
        write_reg(CFG_OUTER, o);
        write_reg(CFG_INNER, n);
        write_reg(CFG_PHASE, {16'h0, ph});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly pixel words with a share of loads that refresh grid values.
    task automatic random_words(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30)
                push_load(8'($urandom), 8'($urandom), $urandom);
            else
                push_pixel(8'($urandom), 8'($urandom));
        end
    endtask

    // Stimulus: directed words, then random words under several settings.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_load(8'd0, 8'd0, 32'h8000_0000);
        push_load(8'd255, 8'd255, 32'h7FFF_FFFF);
        push_load(8'd1, 8'd255, 32'h0001_0000);
        push_pixel(8'd128, 8'd128);
        push_pixel(8'd0, 8'd0);
        push_pixel(8'd255, 8'd255);
        push_pixel(8'd0, 8'd255);
        push_pixel(8'd255, 8'd128);
        push_pixel(8'd130, 8'd128);
        push_pixel(8'd128, 8'd131);
        push_pixel(8'd100, 8'd128);
        push_pixel(8'd128, 8'd60);
        random_words(45);
        // Hold the sender until the pipeline is empty once.
        wait (words_pending.size() == 0 && pixels_due.size() == 0);
        random_words(15);
        set_regs(32'hFFFF_FFFF, 32'd0, 16'd0);
        random_words(55);
        idle_pct = 61;
        set_regs(32'd200000, 32'd60000, 16'hFFFF);
        random_words(55);
        set_regs(32'd1000, 32'd5000, 16'd100);
        random_words(40);
        set_regs(32'd300, 32'hFFFF_FFFF, 16'd12345);
        random_words(20);
        idle_pct = 0;
        set_regs(32'd256, 32'd0, 16'd40000);
        random_words(55);
        set_regs(32'h8000_0000, 32'h2000_0000, 16'd32768);
        random_words(45);
        wait (words_pending.size() == 0 && pixels_due.size() == 0);
        repeat (80) @(posedge i_clk);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Driver: presents the oldest pending word and predicts it on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                if (words_pending[0].req == REQ_LOAD)
                    grid_mem[{words_pending[0].rad, words_pending[0].ang}] =
                        words_pending[0].sample;
                else
                    pixels_due = {pixels_due, convert_pixel(words_pending[0].px,
                                                            words_pending[0].py)};
                void'(words_pending.pop_front());
            end
            if (words_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_start        <= 1'b1;
                i_req_type     <= words_pending[0].req;
                i_grid_radial  <= words_pending[0].rad;
                i_grid_angular <= words_pending[0].ang;
                i_sample_value <= words_pending[0].sample;
                i_pixel_x      <= words_pending[0].px;
                i_pixel_y      <= words_pending[0].py;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: each result word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected result value %h outside %b",
                         $realtime, o_pixel_value, o_outside);
                failed = 1'b1;
            end else begin
                if (o_pixel_value !== pixels_due[0].value) begin
                    $display("%0t: pixel_value expected %h actual %h",
                             $realtime, pixels_due[0].value, o_pixel_value);
                    failed = 1'b1;
                end
                if (o_outside !== pixels_due[0].outs) begin
                    $display("%0t: outside expected %b actual %b",
                             $realtime, pixels_due[0].outs, o_outside);
                    failed = 1'b1;
                end
                void'(pixels_due.pop_front());
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no word moving.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
